/* rtl/core/wmmf_pkg.sv */
// ----------------------------------------------------------------------------
// wmmf_pkg
// Shared types and constants of the 3x3 window min/max filter.
// ----------------------------------------------------------------------------
package wmmf_pkg;

   // Configuration register indexes.
   localparam logic [1:0] CSR_FRAME_WIDTH    = 2'd0;
   localparam logic [1:0] CSR_FRAME_HEIGHT   = 2'd1;
   localparam logic [1:0] CSR_FILTER_MODE    = 2'd2;
   localparam logic [1:0] CSR_EDGE_THRESHOLD = 2'd3;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 11;

   // Filter mode bits: bit 1 selects the edge flag, else bit 0 selects maximum.
   localparam int MODE_EDGE_BIT    = 1;
   localparam int MODE_DILATE_BIT  = 0;

   // Reset values of the registers.
   localparam logic [10:0] FRAME_WIDTH_RESET    = 11'd640;
   localparam logic [10:0] FRAME_HEIGHT_RESET   = 11'd480;
   localparam logic [1:0]  FILTER_MODE_RESET    = 2'd0;
   localparam logic [7:0]  EDGE_THRESHOLD_RESET = 8'd10;

   // Frame size limits.
   localparam logic [10:0] MIN_DIM      = 11'd3;
   localparam logic [10:0] HEIGHT_LIMIT = 11'd1024;

   // Edge flag level.
   localparam logic [7:0] FULL_SCALE = 8'd255;

   typedef struct packed {
      logic [10:0] frame_width;
      logic [10:0] frame_height;
      logic [1:0]  filter_mode;
      logic [7:0]  edge_threshold;
   } cfg_type;

   typedef struct packed {
      logic [7:0] pixel;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic [7:0] value;
      logic [9:0] out_row;
      logic [9:0] out_col;
   } rsp_type;

   // Classified pixel handed from the front to the back part.
   typedef struct packed {
      logic [7:0] pixel;
      logic       emit;
      logic [9:0] out_row;
      logic [9:0] out_col;
   } cmd_type;

endpackage

/* rtl/core/window_min_max_filter_3x3_unit.sv */
// ----------------------------------------------------------------------------
// window_min_max_filter_3x3_unit
// Streaming 3x3 grayscale erosion, dilation and range edge filter.
// ----------------------------------------------------------------------------
// The unit takes one 8-bit pixel per clock in raster order and sustains that
// rate while the result queue has room: each pixel makes one read and one
// write of each of the two line stores, whose single read port and single
// write port set the figure. A result for an interior pixel passes from the
// classify queue through stage A and stage B into the four-entry result
// queue, so a stalled consumer does not stop input until that queue and the
// two-entry classify queue are full. Border pixels give no result. No
// clearing pass runs after reset: a fill count of the line stores makes
// columns never written read as zero, so the unit accepts pixels from the
// first cycle after reset. Registers are to be written only while the unit
// is idle; the unit itself does not enforce this.
// ----------------------------------------------------------------------------
module window_min_max_filter_3x3_unit #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   // Pixel input.
   input  logic                                push,
   input  wmmf_pkg::req_type                   req_data,
   output logic                                full,
   // Filter results.
   output logic                                empty,
   input  logic                                pop,
   output wmmf_pkg::rsp_type                   rsp_data,
   // Register writes.
   input  logic                                csr_write,
   input  logic [wmmf_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [wmmf_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import wmmf_pkg::*;

   localparam int AW        = $clog2(MAX_WIDTH);
   localparam int CMD_DEPTH = 2;
   localparam int OUT_DEPTH = 4;
   localparam int CMD_W     = $bits(cmd_type) + AW;

   cfg_type                      cfg_ff;
   logic                         cmd_push, cmd_full, cmd_pop, cmd_empty;
   cmd_type                      front_cmd, back_cmd;
   logic [AW-1:0]                front_addr, back_addr;
   logic [CMD_W-1:0]             cmd_rdata;
   logic [$clog2(CMD_DEPTH+1)-1:0] cmd_count;
   logic                         rsp_push, rsp_full;
   rsp_type                      back_rsp;
   logic [$clog2(OUT_DEPTH+1)-1:0] rsp_count;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width    <= FRAME_WIDTH_RESET;
         cfg_ff.frame_height   <= FRAME_HEIGHT_RESET;
         cfg_ff.filter_mode    <= FILTER_MODE_RESET;
         cfg_ff.edge_threshold <= EDGE_THRESHOLD_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:    cfg_ff.frame_width    <= csr_wdata[10:0];
            CSR_FRAME_HEIGHT:   cfg_ff.frame_height   <= csr_wdata[10:0];
            CSR_FILTER_MODE:    cfg_ff.filter_mode    <= csr_wdata[1:0];
            CSR_EDGE_THRESHOLD: cfg_ff.edge_threshold <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   wmmf_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .push     (push),
      .req_data (req_data),
      .full     (full),
      .q_full   (cmd_full),
      .q_push   (cmd_push),
      .q_cmd    (front_cmd),
      .q_addr   (front_addr)
   );

   // Queue between classification and filtering.
   wmmf_fifo #(.WIDTH(CMD_W), .DEPTH(CMD_DEPTH)) u_cmd_queue (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .wdata ({front_cmd, front_addr}),
      .full  (cmd_full),
      .pop   (cmd_pop),
      .rdata (cmd_rdata),
      .empty (cmd_empty),
      .count (cmd_count)
   );

   assign back_cmd  = cmd_type'(cmd_rdata[CMD_W-1:AW]);
   assign back_addr = cmd_rdata[AW-1:0];

   wmmf_back #(.MAX_WIDTH(MAX_WIDTH), .OUT_DEPTH(OUT_DEPTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (cmd_empty || (cmd_count == '0)),
      .q_cmd     (back_cmd),
      .q_addr    (back_addr),
      .q_pop     (cmd_pop),
      .out_count (rsp_count),
      .o_push    (rsp_push),
      .o_data    (back_rsp)
   );

   // Result queue; the issue credit in the back part keeps it from overflowing.
   wmmf_fifo #(.WIDTH($bits(rsp_type)), .DEPTH(OUT_DEPTH)) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push && !rsp_full),
      .wdata (back_rsp),
      .full  (rsp_full),
      .pop   (pop),
      .rdata (rsp_data),
      .empty (empty),
      .count (rsp_count)
   );

endmodule

/* rtl/core/wmmf_ram.sv */
// ----------------------------------------------------------------------------
// wmmf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wmmf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // A read at the address being written returns the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/wmmf_fifo.sv */
// ----------------------------------------------------------------------------
// wmmf_fifo
// Small register queue with occupancy count.
// ----------------------------------------------------------------------------
module wmmf_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           wdata,
   output logic                       full,
   input  logic                       pop,
   output logic [WIDTH-1:0]           rdata,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH+1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = slot_ff[rd_ptr_ff];
   assign count   = count_ff;

   // Pointer and count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

/* rtl/core/wmmf_front.sv */
// ----------------------------------------------------------------------------
// wmmf_front
// Tracks the raster position of each accepted pixel and decides whether it
// completes the window of an interior pixel.
// ----------------------------------------------------------------------------
module wmmf_front #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  wmmf_pkg::cfg_type            cfg,
   input  logic                         push,
   input  wmmf_pkg::req_type            req_data,
   output logic                         full,
   input  logic                         q_full,
   output logic                         q_push,
   output wmmf_pkg::cmd_type            q_cmd,
   output logic [$clog2(MAX_WIDTH)-1:0] q_addr
);
   import wmmf_pkg::*;

   localparam int AW   = $clog2(MAX_WIDTH);
   localparam int WW   = $clog2(MAX_WIDTH+1);
   localparam int CMPW = (WW > 11) ? WW : 11;

   logic [9:0]      row_ff, row_in;
   logic [AW-1:0]   col_ff, col_in;
   logic [9:0]      row_cur;
   logic [AW-1:0]   col_cur;
   logic [CMPW-1:0] width_ext, width_lim, col_ext, col_next, col_less;
   logic [10:0]     height_lim, row_next;
   logic            accept;

   assign full   = q_full;
   assign accept = push && !q_full;
   assign q_push = accept;

   // Clamp the frame size to the supported range.
   always_comb begin
      width_ext = CMPW'(cfg.frame_width);
      if (width_ext < CMPW'(MIN_DIM)) begin
         width_lim = CMPW'(MIN_DIM);
      end else if (width_ext > CMPW'(MAX_WIDTH)) begin
         width_lim = CMPW'(MAX_WIDTH);
      end else begin
         width_lim = width_ext;
      end
      if (cfg.frame_height < MIN_DIM) begin
         height_lim = MIN_DIM;
      end else if (cfg.frame_height > HEIGHT_LIMIT) begin
         height_lim = HEIGHT_LIMIT;
      end else begin
         height_lim = cfg.frame_height;
      end
   end

   // Position of this pixel and classification.
   always_comb begin
      row_cur  = req_data.frame_start ? '0 : row_ff;
      col_cur  = req_data.frame_start ? '0 : col_ff;
      col_ext  = CMPW'(col_cur);
      col_less = col_ext - 1'b1;

      q_cmd.pixel   = req_data.pixel;
      q_cmd.emit    = (row_cur >= 10'd2) && (col_ext >= CMPW'(2)) &&
                      ({1'b0, row_cur} < height_lim) && (col_ext < width_lim);
      q_cmd.out_row = row_cur - 1'b1;
      q_cmd.out_col = col_less[9:0];
      q_addr        = col_cur;
   end

   // Advance the raster position.
   always_comb begin
      col_next = col_ext + 1'b1;
      row_next = {1'b0, row_cur} + 1'b1;
      if (col_next >= width_lim) begin
         col_in = '0;
         row_in = (row_next >= height_lim) ? '0 : row_next[9:0];
      end else begin
         col_in = col_next[AW-1:0];
         row_in = row_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (accept) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

endmodule

/* rtl/core/wmmf_back.sv */
// ----------------------------------------------------------------------------
// wmmf_back
// Reads and updates the two line stores, keeps the column minima and maxima
// of the window and produces the filtered value for interior pixels.
// ----------------------------------------------------------------------------
module wmmf_back #(
   parameter int MAX_WIDTH = 1024,
   parameter int OUT_DEPTH = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  wmmf_pkg::cfg_type                cfg,
   input  logic                             q_empty,
   input  wmmf_pkg::cmd_type                q_cmd,
   input  logic [$clog2(MAX_WIDTH)-1:0]     q_addr,
   output logic                             q_pop,
   input  logic [$clog2(OUT_DEPTH+1)-1:0]   out_count,
   output logic                             o_push,
   output wmmf_pkg::rsp_type                o_data
);
   import wmmf_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int SW = $clog2(OUT_DEPTH+1) + 1;

   function automatic logic [7:0] min3(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
      logic [7:0] m;
      m = (a < b) ? a : b;
      return (c < m) ? c : m;
   endfunction

   function automatic logic [7:0] max3(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
      logic [7:0] m;
      m = (a > b) ? a : b;
      return (c > m) ? c : m;
   endfunction

   // Stage A: line store data returns.
   logic          valid_a_ff;
   cmd_type       cmd_a_ff;
   logic [AW-1:0] addr_a_ff;
   logic          fwd_a_ff, blank_a_ff;
   // Stage B: window extremes of an interior pixel.
   logic          valid_b_ff;
   logic [7:0]    min_b_ff, max_b_ff;
   logic [9:0]    row_b_ff, col_b_ff;
   // Line store bookkeeping.
   logic [AW:0]   fill_ff;
   logic [7:0]    fwd_upper_ff, fwd_middle_ff;
   // Minima and maxima of the two previous columns.
   logic [7:0]    cmin_old_ff, cmin_new_ff, cmax_old_ff, cmax_new_ff;

   logic [SW-1:0] pending;
   logic [7:0]    upper_rd, middle_rd, upper_px, middle_px;
   logic [7:0]    col_min, col_max, win_min, win_max, range;

   // Issue only when the output queue can hold every transaction in flight.
   assign pending = SW'(out_count) + SW'(valid_a_ff) + SW'(valid_b_ff);
   assign q_pop   = !q_empty && (pending < SW'(OUT_DEPTH));

   wmmf_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_upper (
      .clock   (clock),
      .wr_en   (valid_a_ff),
      .wr_addr (addr_a_ff),
      .wr_data (middle_px),
      .rd_en   (q_pop),
      .rd_addr (q_addr),
      .rd_data (upper_rd)
   );

   wmmf_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_middle (
      .clock   (clock),
      .wr_en   (valid_a_ff),
      .wr_addr (addr_a_ff),
      .wr_data (cmd_a_ff.pixel),
      .rd_en   (q_pop),
      .rd_addr (q_addr),
      .rd_data (middle_rd)
   );

   // Stage A capture. A read at the column written in the same cycle takes
   // the written values by forwarding; a column never written reads as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else begin
         valid_a_ff <= q_pop;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cmd_a_ff   <= q_cmd;
         addr_a_ff  <= q_addr;
         fwd_a_ff   <= valid_a_ff && (addr_a_ff == q_addr);
         blank_a_ff <= ({1'b0, q_addr} >= fill_ff);
      end
   end

   // Effective column of the window.
   always_comb begin
      if (fwd_a_ff) begin
         upper_px  = fwd_upper_ff;
         middle_px = fwd_middle_ff;
      end else if (blank_a_ff) begin
         upper_px  = '0;
         middle_px = '0;
      end else begin
         upper_px  = upper_rd;
         middle_px = middle_rd;
      end
      col_min = min3(upper_px, middle_px, cmd_a_ff.pixel);
      col_max = max3(upper_px, middle_px, cmd_a_ff.pixel);
      win_min = min3(col_min, cmin_old_ff, cmin_new_ff);
      win_max = max3(col_max, cmax_old_ff, cmax_new_ff);
   end

   // Line store write tracking and column shift.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         cmin_old_ff <= '0;
         cmin_new_ff <= '0;
         cmax_old_ff <= '0;
         cmax_new_ff <= '0;
      end else if (valid_a_ff) begin
         if ({1'b0, addr_a_ff} >= fill_ff) begin
            fill_ff <= {1'b0, addr_a_ff} + 1'b1;
         end
         cmin_old_ff <= cmin_new_ff;
         cmin_new_ff <= col_min;
         cmax_old_ff <= cmax_new_ff;
         cmax_new_ff <= col_max;
      end
   end

   always_ff @(posedge clock) begin
      if (valid_a_ff) begin
         fwd_upper_ff  <= middle_px;
         fwd_middle_ff <= cmd_a_ff.pixel;
      end
   end

   // Stage B capture for interior pixels only.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_b_ff <= 1'b0;
      end else begin
         valid_b_ff <= valid_a_ff && cmd_a_ff.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (valid_a_ff) begin
         min_b_ff <= win_min;
         max_b_ff <= win_max;
         row_b_ff <= cmd_a_ff.out_row;
         col_b_ff <= cmd_a_ff.out_col;
      end
   end

   // Mode selection.
   assign range = max_b_ff - min_b_ff;

   always_comb begin
      priority if (cfg.filter_mode[MODE_EDGE_BIT]) begin
         o_data.value = (range > cfg.edge_threshold) ? FULL_SCALE : '0;
      end else if (cfg.filter_mode[MODE_DILATE_BIT]) begin
         o_data.value = max_b_ff;
      end else begin
         o_data.value = min_b_ff;
      end
      o_data.out_row = row_b_ff;
      o_data.out_col = col_b_ff;
   end

   assign o_push = valid_b_ff;

endmodule
